FILE: hw/rtl/nine_point_laplacian_diffusion_step_macros.svh
// Assertion macros shared by the diffusion step RTL.
`ifndef NINE_POINT_LAPLACIAN_DIFFUSION_STEP_MACROS_SVH
`define NINE_POINT_LAPLACIAN_DIFFUSION_STEP_MACROS_SVH

// check cons in the same cycle as ante
`define NPLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define NPLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/npld_pkg.sv
// Shared types and constants of the diffusion step block.
package npld_pkg;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_LVL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH    = 8;
	localparam int OUT_LVL_W    = $clog2(OUT_DEPTH + 1);

	localparam int ROW_LENGTH_W = 11;
	localparam int ROWS_W       = 13;
	localparam int ROW_BITS     = 12;
	localparam int ROWS_MAX     = 4096;
	localparam int MIN_DIM      = 3;
	localparam int STEP_SCALE_W = 16;

	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RST = 11'd1024;
	localparam logic [ROWS_W-1:0]       ROW_COUNT_RST  = 13'd1024;
	localparam logic [STEP_SCALE_W-1:0] STEP_SCALE_RST = 16'd0;
	localparam logic                    HALF_STEP_RST  = 1'b1;

	typedef enum logic [1:0] {
		REG_ROW_LENGTH,
		REG_ROW_COUNT,
		REG_STEP_SCALE,
		REG_HALF_STEP
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_SKIP,
		KIND_PASS,
		KIND_DIFF,
		KIND_FLUSH_WIN,
		KIND_FLUSH_RAM
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  last;
	} cmd_t;

endpackage

FILE: hw/rtl/npld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/npld_fifo.sv
// Small register FIFO with fill level, used between front and back and on the result side.
`include "nine_point_laplacian_diffusion_step_macros.svh"

module npld_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rptr_q];
	assign empty = (count_q == '0);
	assign level = count_q;

	`NPLD_ASSERT_NOW(a_no_overflow, clk, arst_n, push, int'(count_q) < DEPTH, "fifo push while full")
	`NPLD_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, count_q != '0, "fifo pop while empty")

endmodule

FILE: hw/rtl/npld_front.sv
// Front end: accepts items, tracks raster position, keeps line buffers, classifies each item.
`include "nine_point_laplacian_diffusion_step_macros.svh"

module npld_front #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 restart,
	input  logic [npld_pkg::ROW_LENGTH_W-1:0]    row_length,
	input  logic [npld_pkg::ROWS_W-1:0]          row_count,
	input  logic                                 push,
	input  logic                                 flush,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                 full,
	input  logic [npld_pkg::QUEUE_LVL_W-1:0]     q_level,
	output logic                                 q_push,
	output npld_pkg::cmd_t                       q_cmd,
	output logic signed [SAMPLE_BITS-1:0]        q_top,
	output logic signed [SAMPLE_BITS-1:0]        q_mid,
	output logic signed [SAMPLE_BITS-1:0]        q_bot
);

	localparam int AW = $clog2(MAX_ROW_LENGTH);
	localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
	localparam int RB = npld_pkg::ROW_BITS;
	localparam int RW = npld_pkg::ROWS_W;

	logic [AW-1:0]          col_q, col_d;
	logic [RB-1:0]          row_q, row_d;
	logic                   par_q, par_d;
	logic                   done_q, done_d;
	logic [LW-1:0]          fidx_q, fidx_d;
	logic [LW-1:0]          len_eff;
	logic [RW-1:0]          rows_eff;
	logic                   col_wrap;
	logic                   row_wrap;
	logic                   fire;
	logic                   emit;
	logic                   ram_we;
	logic [AW-1:0]          rd_addr;
	npld_pkg::cmd_t         cmd_d;

	logic                   s1_valid_q;
	npld_pkg::cmd_t         cmd_s1;
	logic [SAMPLE_BITS-1:0] x_s1;
	logic                   par_s1;
	logic [SAMPLE_BITS-1:0] rd0;
	logic [SAMPLE_BITS-1:0] rd1;

	always_comb begin
		if (32'(row_length) < 32'(npld_pkg::MIN_DIM)) begin
			len_eff = LW'(npld_pkg::MIN_DIM);
		end else if (32'(row_length) > 32'(MAX_ROW_LENGTH)) begin
			len_eff = LW'(MAX_ROW_LENGTH);
		end else begin
			len_eff = LW'(row_length);
		end
		if (32'(row_count) < 32'(npld_pkg::MIN_DIM)) begin
			rows_eff = RW'(npld_pkg::MIN_DIM);
		end else if (32'(row_count) > 32'(npld_pkg::ROWS_MAX)) begin
			rows_eff = RW'(npld_pkg::ROWS_MAX);
		end else begin
			rows_eff = row_count;
		end
	end

	assign full     = (int'(q_level) + int'(s1_valid_q)) >= npld_pkg::QUEUE_DEPTH;
	assign fire     = push && !full;
	assign col_wrap = (LW'(col_q) + LW'(1)) == len_eff;
	assign row_wrap = (RW'(row_q) + RW'(1)) == rows_eff;

	always_comb begin
		cmd_d.kind = npld_pkg::KIND_SKIP;
		cmd_d.last = 1'b0;
		emit       = 1'b0;
		ram_we     = 1'b0;
		col_d      = col_q;
		row_d      = row_q;
		par_d      = par_q;
		done_d     = done_q;
		fidx_d     = fidx_q;
		rd_addr    = done_q ? AW'(fidx_q - LW'(1)) : col_q;
		if (fire) begin
			if (done_q) begin
				emit       = 1'b1;
				cmd_d.kind = (fidx_q == '0) ? npld_pkg::KIND_FLUSH_WIN : npld_pkg::KIND_FLUSH_RAM;
				cmd_d.last = (fidx_q == len_eff);
				if (cmd_d.last) begin
					col_d  = '0;
					row_d  = '0;
					par_d  = 1'b0;
					done_d = 1'b0;
					fidx_d = '0;
				end else begin
					fidx_d = fidx_q + LW'(1);
				end
			end else if (!flush) begin
				emit   = 1'b1;
				ram_we = 1'b1;
				if (row_q >= RB'(2) && col_q >= AW'(2)) begin
					cmd_d.kind = npld_pkg::KIND_DIFF;
				end else if ((row_q >= RB'(1) && col_q >= AW'(1)) ||
						(row_q >= RB'(2) && col_q == '0)) begin
					cmd_d.kind = npld_pkg::KIND_PASS;
				end
				if (col_wrap) begin
					col_d = '0;
					par_d = ~par_q;
					if (row_wrap) begin
						row_d  = '0;
						done_d = 1'b1;
					end else begin
						row_d = row_q + RB'(1);
					end
				end else begin
					col_d = col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			par_q      <= 1'b0;
			done_q     <= 1'b0;
			fidx_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= emit;
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				par_q  <= 1'b0;
				done_q <= 1'b0;
				fidx_q <= '0;
			end else begin
				col_q  <= col_d;
				row_q  <= row_d;
				par_q  <= par_d;
				done_q <= done_d;
				fidx_q <= fidx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_d;
		x_s1   <= sample_in;
		par_s1 <= par_q;
	end

	npld_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_ROW_LENGTH)
	) u_line0 (
		.clk   (clk),
		.we    (ram_we && !par_q),
		.waddr (col_q),
		.wdata (sample_in),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	npld_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_ROW_LENGTH)
	) u_line1 (
		.clk   (clk),
		.we    (ram_we && par_q),
		.waddr (col_q),
		.wdata (sample_in),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	assign q_push = s1_valid_q;
	assign q_cmd  = cmd_s1;
	assign q_top  = $signed(par_s1 ? rd1 : rd0);
	assign q_mid  = $signed(par_s1 ? rd0 : rd1);
	assign q_bot  = $signed(x_s1);

	`NPLD_ASSERT_NEXT(a_frame_restart, clk, arst_n, fire && done_q && cmd_d.last, !done_q && fidx_q == '0 && col_q == '0, "frame did not restart after last item")

endmodule

FILE: hw/rtl/npld_back.sv
// Back end: 3x3 window, nine-point Laplacian, scaling, rounding and saturation.
`include "nine_point_laplacian_diffusion_step_macros.svh"

module npld_back #(
	parameter int SAMPLE_BITS         = 16,
	parameter int SCALE_FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  npld_pkg::cmd_t                       q_cmd,
	input  logic signed [SAMPLE_BITS-1:0]        q_top,
	input  logic signed [SAMPLE_BITS-1:0]        q_mid,
	input  logic signed [SAMPLE_BITS-1:0]        q_bot,
	output logic                                 q_pop,
	input  logic [npld_pkg::OUT_LVL_W-1:0]       out_level,
	input  logic [npld_pkg::STEP_SCALE_W-1:0]    step_scale,
	input  logic                                 half_step_mode,
	output logic                                 out_push,
	output logic signed [SAMPLE_BITS-1:0]        out_sample,
	output logic                                 out_last
);

	localparam int S    = SAMPLE_BITS;
	localparam int F    = SCALE_FRACTION_BITS;
	localparam int ES   = S + 2;
	localparam int LAPW = S + 6;
	localparam int PW   = LAPW + npld_pkg::STEP_SCALE_W + 1;
	localparam int SW   = PW + 2;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW - S + 1){1'b0}}, {(S - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW - S + 1){1'b1}}, {(S - 1){1'b0}}};
	localparam logic signed [PW:0]   RND_WHOLE = {{PW{1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [PW:0]   RND_HALF  = {{PW{1'b0}}, 1'b1} << F;

	logic signed [S-1:0]    win_q [9];
	logic signed [S-1:0]    nw [9];
	logic                   shift;
	logic signed [S-1:0]    centre_d;
	logic [2:0]             inflight;

	logic                   valid_s1_q, valid_s2_q, valid_s3_q, valid_s4_q;
	npld_pkg::cmd_t         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [S-1:0]    centre_s1, centre_s2, centre_s3, centre_s4;
	logic signed [ES-1:0]   edges_s1;
	logic signed [ES-1:0]   corners_s1;
	logic signed [LAPW-1:0] lap_s2;
	logic signed [PW-1:0]   prod_s3;
	logic signed [PW:0]     rnd_v;
	logic signed [PW:0]     q_s4;
	logic signed [SW-1:0]   sum;

	assign inflight = 3'(valid_s1_q) + 3'(valid_s2_q) + 3'(valid_s3_q) + 3'(valid_s4_q);
	assign q_pop    = !q_empty && ((int'(out_level) + int'(inflight)) < npld_pkg::OUT_DEPTH);
	assign shift    = q_pop && (q_cmd.kind == npld_pkg::KIND_SKIP ||
			q_cmd.kind == npld_pkg::KIND_PASS || q_cmd.kind == npld_pkg::KIND_DIFF);

	always_comb begin
		nw[0] = win_q[1];
		nw[1] = win_q[2];
		nw[2] = q_top;
		nw[3] = win_q[4];
		nw[4] = win_q[5];
		nw[5] = q_mid;
		nw[6] = win_q[7];
		nw[7] = win_q[8];
		nw[8] = q_bot;
		case (q_cmd.kind)
			npld_pkg::KIND_FLUSH_WIN: begin
				centre_d = win_q[5];
			end
			npld_pkg::KIND_FLUSH_RAM: begin
				centre_d = q_mid;
			end
			default: begin
				centre_d = nw[4];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
			valid_s4_q <= 1'b0;
		end else begin
			valid_s1_q <= q_pop;
			valid_s2_q <= valid_s1_q;
			valid_s3_q <= valid_s2_q;
			valid_s4_q <= valid_s3_q;
		end
	end

	assign rnd_v = (PW + 1)'(prod_s3) + (half_step_mode ? RND_HALF : RND_WHOLE);

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= nw;
		end
		cmd_s1     <= q_cmd;
		centre_s1  <= centre_d;
		edges_s1   <= ES'(nw[1]) + ES'(nw[3]) + ES'(nw[5]) + ES'(nw[7]);
		corners_s1 <= ES'(nw[0]) + ES'(nw[2]) + ES'(nw[6]) + ES'(nw[8]);

		cmd_s2     <= cmd_s1;
		centre_s2  <= centre_s1;
		lap_s2     <= (LAPW'(edges_s1) <<< 2) + LAPW'(corners_s1)
				- (LAPW'(centre_s1) <<< 4) - (LAPW'(centre_s1) <<< 2);

		cmd_s3     <= cmd_s2;
		centre_s3  <= centre_s2;
		prod_s3    <= PW'(lap_s2) * PW'($signed({1'b0, step_scale}));

		cmd_s4     <= cmd_s3;
		centre_s4  <= centre_s3;
		q_s4       <= half_step_mode ? (rnd_v >>> (F + 1)) : (rnd_v >>> F);
	end

	assign sum = SW'(q_s4) + SW'(centre_s4);

	always_comb begin
		out_sample = centre_s4;
		if (cmd_s4.kind == npld_pkg::KIND_DIFF) begin
			if (sum > SAT_HI) begin
				out_sample = SAT_HI[S-1:0];
			end else if (sum < SAT_LO) begin
				out_sample = SAT_LO[S-1:0];
			end else begin
				out_sample = sum[S-1:0];
			end
		end
	end

	assign out_push = valid_s4_q && (cmd_s4.kind != npld_pkg::KIND_SKIP);
	assign out_last = cmd_s4.last;

	`NPLD_ASSERT_NOW(a_pipe_depth, clk, arst_n, valid_s4_q, $past(valid_s1_q, 3), "back pipeline lost its timing")
	`NPLD_ASSERT_NOW(a_pop_room, clk, arst_n, q_pop, (int'(out_level) + int'(inflight)) < npld_pkg::OUT_DEPTH, "pop without result room")

endmodule

FILE: hw/rtl/nine_point_laplacian_diffusion_step.sv
// Top level of the nine-point Laplacian diffusion step: register port, front, queue, back, result queue.
//
//   channel   handshake                     payload
//   input     push / full                   sample_in, flush
//   result    pop / empty                   sample_out, last_of_frame
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item per cycle while full stays low; each item passes the front register, the queue
// and four back stages before its result is ready.
// A point leaves one row plus one sample after it arrives; row_length + 1 flush
// items drain a frame. Each line buffer is read once and written at most once per cycle.
// Reset needs no clearing pass. full rises when the queue plus the front register
// hold 4 items; the back stops pulling when results and work in flight reach 8.
module nine_point_laplacian_diffusion_step #(
	parameter int MAX_ROW_LENGTH      = 1024,
	parameter int SAMPLE_BITS         = 16,
	parameter int SCALE_FRACTION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [npld_pkg::ADDR_W-1:0]       paddr,
	input  logic [npld_pkg::DATA_W-1:0]       pwdata,
	output logic [npld_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              push,
	output logic                              full,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	input  logic                              flush,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [SAMPLE_BITS-1:0]     sample_out,
	output logic                              last_of_frame
);

	localparam int QDW = $bits(npld_pkg::cmd_t) + 3 * SAMPLE_BITS;
	localparam int ODW = SAMPLE_BITS + 1;

	logic [npld_pkg::ROW_LENGTH_W-1:0] row_length_q;
	logic [npld_pkg::ROWS_W-1:0]       row_count_q;
	logic [npld_pkg::STEP_SCALE_W-1:0] step_scale_q;
	logic                              half_step_q;
	npld_pkg::reg_idx_t                reg_idx;
	logic                              cfg_we;
	logic                              restart;

	logic                              f_push;
	npld_pkg::cmd_t                    f_cmd;
	logic signed [SAMPLE_BITS-1:0]     f_top, f_mid, f_bot;
	logic [QDW-1:0]                    q_rdata;
	logic                              q_empty;
	logic                              q_pop;
	logic [npld_pkg::QUEUE_LVL_W-1:0]  q_level;
	npld_pkg::cmd_t                    q_cmd;
	logic signed [SAMPLE_BITS-1:0]     q_top, q_mid, q_bot;

	logic                              b_push;
	logic signed [SAMPLE_BITS-1:0]     b_sample;
	logic                              b_last;
	logic [ODW-1:0]                    o_rdata;
	logic [npld_pkg::OUT_LVL_W-1:0]    o_level;

	assign pready  = 1'b1;
	assign reg_idx = npld_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite && pready;
	assign restart = cfg_we &&
			(reg_idx == npld_pkg::REG_ROW_LENGTH || reg_idx == npld_pkg::REG_ROW_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= npld_pkg::ROW_LENGTH_RST;
			row_count_q  <= npld_pkg::ROW_COUNT_RST;
			step_scale_q <= npld_pkg::STEP_SCALE_RST;
			half_step_q  <= npld_pkg::HALF_STEP_RST;
		end else if (cfg_we) begin
			case (reg_idx)
				npld_pkg::REG_ROW_LENGTH: begin
					row_length_q <= pwdata[npld_pkg::ROW_LENGTH_W-1:0];
				end
				npld_pkg::REG_ROW_COUNT: begin
					row_count_q <= pwdata[npld_pkg::ROWS_W-1:0];
				end
				npld_pkg::REG_STEP_SCALE: begin
					step_scale_q <= pwdata[npld_pkg::STEP_SCALE_W-1:0];
				end
				default: begin
					half_step_q <= pwdata[0];
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			npld_pkg::REG_ROW_LENGTH: begin
				prdata = npld_pkg::DATA_W'(row_length_q);
			end
			npld_pkg::REG_ROW_COUNT: begin
				prdata = npld_pkg::DATA_W'(row_count_q);
			end
			npld_pkg::REG_STEP_SCALE: begin
				prdata = npld_pkg::DATA_W'(step_scale_q);
			end
			default: begin
				prdata = npld_pkg::DATA_W'(half_step_q);
			end
		endcase
	end

	npld_front #(
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.row_length (row_length_q),
		.row_count  (row_count_q),
		.push       (push),
		.flush      (flush),
		.sample_in  (sample_in),
		.full       (full),
		.q_level    (q_level),
		.q_push     (f_push),
		.q_cmd      (f_cmd),
		.q_top      (f_top),
		.q_mid      (f_mid),
		.q_bot      (f_bot)
	);

	npld_fifo #(
		.WIDTH (QDW),
		.DEPTH (npld_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_cmd, f_top, f_mid, f_bot}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.level  (q_level)
	);

	assign {q_cmd, q_top, q_mid, q_bot} = q_rdata;

	npld_back #(
		.SAMPLE_BITS         (SAMPLE_BITS),
		.SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (q_cmd),
		.q_top          (q_top),
		.q_mid          (q_mid),
		.q_bot          (q_bot),
		.q_pop          (q_pop),
		.out_level      (o_level),
		.step_scale     (step_scale_q),
		.half_step_mode (half_step_q),
		.out_push       (b_push),
		.out_sample     (b_sample),
		.out_last       (b_last)
	);

	npld_fifo #(
		.WIDTH (ODW),
		.DEPTH (npld_pkg::OUT_DEPTH)
	) u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  ({b_sample, b_last}),
		.pop    (pop && !empty),
		.rdata  (o_rdata),
		.empty  (empty),
		.level  (o_level)
	);

	assign {sample_out, last_of_frame} = o_rdata;

endmodule
